// ===== rtl/cprp_pkg.sv =====
// ----------------------------------------------------------------------------
// cprp_pkg - shared types and helpers of the playback clock
// Opcodes, sequencer states, mul/div request and response bundles, and the
// saturation helpers used on quotients and on the pts offset add.
// ----------------------------------------------------------------------------
package cprp_pkg;

	localparam int unsigned W = 64;

	localparam logic [W-1:0] MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [W-1:0] SIGN64 = 64'h8000_0000_0000_0000;

	localparam logic [31:0] FREQ_RESET = 32'd50000000;

	localparam logic [2:0] OP_READ   = 3'd0;
	localparam logic [2:0] OP_SPEED  = 3'd1;
	localparam logic [2:0] OP_DISC   = 3'd2;
	localparam logic [2:0] OP_PAUSE  = 3'd3;
	localparam logic [2:0] OP_RESUME = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPLY,
		ST_NF_GO,
		ST_NF_WAIT,
		ST_SS_GO,
		ST_SS_WAIT,
		ST_PT_GO,
		ST_PT_WAIT,
		ST_ABS_GO,
		ST_ABS_WAIT,
		ST_OUT
	} seq_state_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_MUL,
		MD_CHK,
		MD_DIV,
		MD_DONE
	} md_state_t;

	typedef struct packed {
		logic         start;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] d;
	} md_req_t;

	typedef struct packed {
		logic         done;
		logic         ovf;
		logic [W-1:0] q;
	} md_rsp_t;

	// Apply the sign to an unsigned quotient magnitude and clamp to int64.
	function automatic logic [W-1:0] sat_quot(input logic [W-1:0] q, input logic ovf,
		input logic neg);
		logic [W-1:0] r;
		if (q == '0) begin
			r = '0;
		end else if (!neg) begin
			r = (ovf || q > MASK63) ? MASK63 : q;
		end else begin
			r = (ovf || q > SIGN64) ? SIGN64 : (~q + 64'd1);
		end
		return r;
	endfunction

	function automatic logic [W-1:0] sat_add64(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W-1:0] s;
		logic [W-1:0] r;
		s = a + b;
		if (((a ^ b) & SIGN64) == '0 && ((a ^ s) & SIGN64) != '0) begin
			r = a[W-1] ? SIGN64 : MASK63;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

// ===== rtl/cprp_muldiv.sv =====
// ----------------------------------------------------------------------------
// cprp_muldiv - shared unsigned multiply-divide unit
// Computes (a*b)/d with a 128-bit product: four 32x32 partial products, one
// per cycle, then a restoring divide at one quotient bit per cycle. Flags an
// overflow when the quotient needs more than 64 bits.
// ----------------------------------------------------------------------------
module cprp_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  cprp_pkg::md_req_t req,
	output cprp_pkg::md_rsp_t rsp
);

	cprp_pkg::md_state_t state_q, state_d;

	logic [63:0]  a_q, b_q, d_q;
	logic [63:0]  rem_q, lo_q;
	logic [5:0]   step_q;
	logic         ovf_q;

	logic [31:0]  a_half, b_half;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [64:0]  rem_sh, diff;
	logic         ge;

	assign a_half = step_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_half = step_q[1] ? b_q[63:32] : b_q[31:0];
	assign pp     = {32'd0, a_half} * {32'd0, b_half};

	always_comb begin
		case (step_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	assign rem_sh = {rem_q, lo_q[63]};
	assign diff   = rem_sh - {1'b0, d_q};
	assign ge     = rem_sh >= {1'b0, d_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			cprp_pkg::MD_IDLE: if (req.start) state_d = cprp_pkg::MD_MUL;
			cprp_pkg::MD_MUL:  if (step_q[1:0] == 2'd3) state_d = cprp_pkg::MD_CHK;
			cprp_pkg::MD_CHK: begin
				if (rem_q >= d_q) state_d = cprp_pkg::MD_DONE;
				else              state_d = cprp_pkg::MD_DIV;
			end
			cprp_pkg::MD_DIV:  if (step_q == 6'd63) state_d = cprp_pkg::MD_DONE;
			cprp_pkg::MD_DONE: state_d = cprp_pkg::MD_IDLE;
			default:           state_d = cprp_pkg::MD_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == cprp_pkg::MD_DONE);
		rsp.ovf  = ovf_q;
		rsp.q    = lo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cprp_pkg::MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cprp_pkg::MD_IDLE: begin
				if (req.start) begin
					a_q    <= req.a;
					b_q    <= req.b;
					d_q    <= req.d;
					rem_q  <= '0;
					lo_q   <= '0;
					step_q <= '0;
					ovf_q  <= 1'b0;
				end
			end
			cprp_pkg::MD_MUL: begin
				{rem_q, lo_q} <= {rem_q, lo_q} + pp_sh;
				step_q        <= (step_q[1:0] == 2'd3) ? 6'd0 : step_q + 6'd1;
			end
			cprp_pkg::MD_CHK: begin
				ovf_q <= (rem_q >= d_q);
				// an overflowing quotient reads as all ones
				if (rem_q >= d_q) lo_q <= '1;
			end
			cprp_pkg::MD_DIV: begin
				// one restoring step: quotient bits shift into lo
				rem_q  <= ge ? diff[63:0] : rem_sh[63:0];
				lo_q   <= {lo_q[62:0], ge};
				step_q <= step_q + 6'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/playback_clock_rate_pause_unit.sv =====
// ----------------------------------------------------------------------------
// playback_clock_rate_pause_unit - media presentation clock
// Read, set speed, discontinuity, pause and resume commands against a
// free-running counter value; every command returns playing and absolute time.
//
//   channel  | direction | signals                        | contents
//   s_*      | in        | s_tvalid s_tready s_tdata s_tuser | one command
//   m_*      | out       | m_tvalid m_tready m_tdata      | one result per command
//   cfg_*    | in        | cfg_we cfg_wdata               | counter frequency
//
// A command goes through apply, one pass on the shared unit per quotient and output,
// then back to idle; a nonzero set speed adds the rate and rescale passes ahead of
// the playing and absolute time passes. Each pass is issue, 4 partial products,
// overflow check, 64 divide steps and done. An overflowing pass skips the divide steps.
// s_tready is high only while the sequencer is idle; a finished result sits in the output register, so a new
// command is taken while it waits for m_tready. Reset sets control and clock state to their defaults.
// ----------------------------------------------------------------------------
module playback_clock_rate_pause_unit #(
	parameter int unsigned TIME_BASE    = 1000000,
	parameter int unsigned SPEED_NORMAL = 1000
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [143:0]  s_tdata,   // counter_now[62:0], speed[79:63], new_pts[142:80]
	input  logic [2:0]    s_tuser,   // opcode[2:0]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,   // playing_time[63:0], absolute_time[126:64]
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata
);

	cprp_pkg::seq_state_t state_q, state_d;

	logic [31:0]  freq_q;
	logic [63:0]  start_q, pause_q, eff_q, pts_off_q, nf_q, play_q;
	logic         anchor_q;
	logic [2:0]   op_q;
	logic [62:0]  now_q;
	logic [16:0]  spd_q;
	logic [62:0]  pts_q;
	logic         neg_q;
	logic [62:0]  abs_q;

	cprp_pkg::md_req_t md_req;
	cprp_pkg::md_rsp_t md_rsp;

	logic [63:0] freq_eff, now64, ref64, x_sel, b_sel, d_sel, sq;
	logic [63:0] eff_mag, nf_mag, nf_r;
	logic [16:0] spd_mag;
	logic        neg_sel, spd_zero, out_load;

	cprp_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign freq_eff = (freq_q == '0) ? 64'd1 : {32'd0, freq_q};
	assign now64    = {1'b0, now_q};
	assign ref64    = (pause_q != '0) ? pause_q : now64;
	assign eff_mag  = eff_q[63] ? (~eff_q + 64'd1) : eff_q;
	assign nf_mag   = nf_q[63] ? (~nf_q + 64'd1) : nf_q;
	assign spd_mag  = spd_q[16] ? (~spd_q + 17'd1) : spd_q;
	assign spd_zero = (spd_q == '0);
	assign sq       = cprp_pkg::sat_quot(md_rsp.q, md_rsp.ovf, neg_q);
	assign nf_r     = (md_rsp.q == '0) ? 64'd1 : md_rsp.q;
	assign out_load = (state_q == cprp_pkg::ST_OUT) && (!m_tvalid || m_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cprp_pkg::ST_IDLE:  if (s_tvalid) state_d = cprp_pkg::ST_APPLY;
			cprp_pkg::ST_APPLY: begin
				if (op_q == cprp_pkg::OP_SPEED && !spd_zero) state_d = cprp_pkg::ST_NF_GO;
				else                                         state_d = cprp_pkg::ST_PT_GO;
			end
			cprp_pkg::ST_NF_GO:    state_d = cprp_pkg::ST_NF_WAIT;
			cprp_pkg::ST_NF_WAIT:  if (md_rsp.done) state_d = cprp_pkg::ST_SS_GO;
			cprp_pkg::ST_SS_GO:    state_d = cprp_pkg::ST_SS_WAIT;
			cprp_pkg::ST_SS_WAIT:  if (md_rsp.done) state_d = cprp_pkg::ST_PT_GO;
			cprp_pkg::ST_PT_GO:    state_d = cprp_pkg::ST_PT_WAIT;
			cprp_pkg::ST_PT_WAIT:  if (md_rsp.done) state_d = cprp_pkg::ST_ABS_GO;
			cprp_pkg::ST_ABS_GO:   state_d = cprp_pkg::ST_ABS_WAIT;
			cprp_pkg::ST_ABS_WAIT: if (md_rsp.done) state_d = cprp_pkg::ST_OUT;
			cprp_pkg::ST_OUT:      if (!m_tvalid || m_tready) state_d = cprp_pkg::ST_IDLE;
			default:               state_d = cprp_pkg::ST_IDLE;
		endcase
	end

	// operand selection for the shared unit
	always_comb begin
		s_tready = (state_q == cprp_pkg::ST_IDLE);
		x_sel    = now64;
		b_sel    = 64'(TIME_BASE);
		d_sel    = freq_eff;
		neg_sel  = 1'b0;
		case (state_q)
			cprp_pkg::ST_NF_GO: begin
				x_sel = freq_eff;
				b_sel = 64'(SPEED_NORMAL);
				d_sel = {47'd0, spd_mag};
			end
			cprp_pkg::ST_SS_GO: begin
				x_sel   = now64 - start_q;
				b_sel   = nf_mag;
				d_sel   = eff_mag;
				neg_sel = x_sel[63] ^ nf_q[63] ^ eff_q[63];
			end
			cprp_pkg::ST_PT_GO: begin
				x_sel   = ref64 - start_q;
				d_sel   = eff_mag;
				neg_sel = x_sel[63] ^ eff_q[63];
			end
			default: begin
			end
		endcase
		md_req.start = (state_q == cprp_pkg::ST_NF_GO) || (state_q == cprp_pkg::ST_SS_GO)
			|| (state_q == cprp_pkg::ST_PT_GO) || (state_q == cprp_pkg::ST_ABS_GO);
		md_req.a     = x_sel[63] ? (~x_sel + 64'd1) : x_sel;
		md_req.b     = b_sel;
		md_req.d     = d_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cprp_pkg::ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)      m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q    <= cprp_pkg::FREQ_RESET;
			start_q   <= '0;
			pause_q   <= '0;
			eff_q     <= {32'd0, cprp_pkg::FREQ_RESET};
			pts_off_q <= '0;
			anchor_q  <= 1'b1;
		end else begin
			if (cfg_we) freq_q <= cfg_wdata;
			if (state_q == cprp_pkg::ST_APPLY) begin
				case (op_q)
					cprp_pkg::OP_READ: begin
						if (anchor_q) begin
							start_q   <= now64;
							eff_q     <= freq_eff;
							pause_q   <= '0;
							pts_off_q <= '0;
							anchor_q  <= 1'b0;
						end
					end
					cprp_pkg::OP_SPEED: begin
						if (spd_zero) begin
							if (pause_q == '0) pause_q <= now64;
						end else if (pause_q != '0) begin
							// resume before rescaling
							start_q <= start_q + (now64 - pause_q);
							pause_q <= '0;
						end
					end
					cprp_pkg::OP_DISC: begin
						start_q   <= now64;
						if (pause_q != '0) pause_q <= now64;
						pts_off_q <= {pts_q[62], pts_q};
						anchor_q  <= 1'b0;
					end
					cprp_pkg::OP_PAUSE: begin
						if (pause_q == '0) pause_q <= now64;
					end
					cprp_pkg::OP_RESUME: begin
						if (pause_q != '0) begin
							start_q <= start_q + (now64 - pause_q);
							pause_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == cprp_pkg::ST_SS_WAIT && md_rsp.done) begin
				start_q <= now64 - sq;
				eff_q   <= nf_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			now_q <= s_tdata[62:0];
			spd_q <= s_tdata[79:63];
			pts_q <= s_tdata[142:80];
		end
		if (md_req.start) neg_q <= neg_sel;
		if (state_q == cprp_pkg::ST_NF_WAIT && md_rsp.done) begin
			nf_q <= spd_q[16] ? (~nf_r + 64'd1) : nf_r;
		end
		if (state_q == cprp_pkg::ST_PT_WAIT && md_rsp.done) begin
			play_q <= cprp_pkg::sat_add64(sq, pts_off_q);
		end
		if (state_q == cprp_pkg::ST_ABS_WAIT && md_rsp.done) begin
			abs_q <= sq[62:0];
		end
		if (out_load) begin
			m_tdata <= {1'b0, abs_q, play_q};
		end
	end

endmodule

// ===== rtl/cprp_checker.sv =====
// ----------------------------------------------------------------------------
// cprp_checker - port-level checks of the playback clock
// Watches both stream sides and the result padding; bound to the top level.
// ----------------------------------------------------------------------------
module cprp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// the block is busy right after taking a command
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// ready only drops because a command was taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input ready dropped without a transfer");

	// absolute time is 63 bits, the pad bit stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[127])
		else $error("result pad bit set");

endmodule

bind playback_clock_rate_pause_unit cprp_checker u_cprp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/tb_playback_clock_rate_pause_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_playback_clock_rate_pause_unit - self-checking bench of the playback clock
// Streams clock commands through the slave port and checks every result
// against a cycle-free predictor of the presentation clock, built on 128-bit
// products. A directed opener covers anchoring, speed extremes, pause and
// resume corners, discontinuities and spare opcodes. Random phases follow
// under several counter frequencies, with bursty input and receiver stalls.
// ----------------------------------------------------------------------------
module tb_playback_clock_rate_pause_unit;

	localparam int unsigned TIME_BASE_TB    = 1000000;
	localparam int unsigned SPEED_NORMAL_TB = 1000;
	localparam int          RANDOM_PER_SET  = 282;
	localparam int          DRAIN_CYCLES    = 400;

	localparam logic [2:0]  OP_SPARE_LO = 3'd5;
	localparam logic [2:0]  OP_SPARE_HI = 3'd7;

	localparam logic [62:0] NOW_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [62:0] PTS_MAX = 63'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [62:0] PTS_MIN = 63'h4000_0000_0000_0000;

	typedef struct packed {
		logic [2:0]  op;
		logic [62:0] now;
		logic [16:0] speed;
		logic [62:0] pts;
	} clock_cmd_t;

	typedef struct packed {
		logic [63:0] play;
		logic [62:0] abs_units;
	} reading_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [143:0]  s_tdata;   // counter_now[62:0], speed[79:63], new_pts[142:80]
	logic [2:0]    s_tuser;   // opcode[2:0]
	logic          m_tvalid;
	logic          m_tready;
	logic [127:0]  m_tdata;   // playing_time[63:0], absolute_time[126:64]
	logic          cfg_we;
	logic [31:0]   cfg_wdata;

	playback_clock_rate_pause_unit #(
		.TIME_BASE    (TIME_BASE_TB),
		.SPEED_NORMAL (SPEED_NORMAL_TB)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted clock state
	logic [31:0] tick_freq       = cprp_pkg::FREQ_RESET;
	logic [63:0] pres_start      = '0;
	logic [63:0] pres_pause      = '0;
	logic [63:0] pres_rate       = {32'd0, cprp_pkg::FREQ_RESET};
	logic [63:0] pres_offset     = '0;
	logic        pres_unanchored = 1'b1;

	clock_cmd_t  pending_cmds[$];
	reading_t    due_readings[$];

	logic [62:0] gen_tick = 63'd0;
	int          speed_menu[6] = '{1000, 2000, 500, -1000, 1500, -250};
	logic [31:0] freq_plan[7]  = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd27000000, 32'd0,
		32'd90000, 32'd50000000};

	int          err_cnt = 0;
	int          readings_checked = 0;
	int          cmds_taken = 0;
	logic        cmd_fire = 1'b0;
	logic        tx_gaps = 1'b1;
	int          rx_mode = 1;
	int          gap_left = 0;
	int          burst_left = 1;
	int          stall_left = 0;
	clock_cmd_t  next_cmd;
	clock_cmd_t  seen_cmd;
	reading_t    got;
	reading_t    want;

	task automatic flag_mismatch(input string what);
		$display("ERROR @%0t: %s", $realtime, what);
		err_cnt++;
	endtask

	function automatic logic [63:0] tick_rate();
		return (tick_freq == '0) ? 64'd1 : {32'd0, tick_freq};
	endfunction

	// signed a*b/d, truncated toward zero, clamped to the int64 range
	function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] d);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [63:0]  md;
		logic [127:0] q;
		logic         neg;
		ma  = a[63] ? 64'd0 - a : a;
		mb  = b[63] ? 64'd0 - b : b;
		md  = d[63] ? 64'd0 - d : d;
		neg = a[63] ^ b[63] ^ d[63];
		q   = ({64'd0, ma} * {64'd0, mb}) / {64'd0, md};
		if (q == '0)
			return '0;
		if (!neg)
			return (q[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
		if (q[127:64] != '0 || (q[63] && q[62:0] != '0))
			return 64'h8000_0000_0000_0000;
		return 64'd0 - q[63:0];
	endfunction

	function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic void freeze(input logic [63:0] at);
		if (pres_pause == '0)
			pres_pause = at;
	endfunction

	function automatic void unfreeze(input logic [63:0] at);
		if (pres_pause != '0) begin
			pres_start = pres_start + (at - pres_pause);
			pres_pause = '0;
		end
	endfunction

	// apply one command to the predicted clock and return its reading
	function automatic reading_t advance_clock(input clock_cmd_t c);
		logic [63:0]  now;
		logic [63:0]  spd;
		logic [63:0]  mag;
		logic [63:0]  rate;
		logic [63:0]  held;
		logic [127:0] absq;
		reading_t     r;
		now = {1'b0, c.now};
		spd = {{47{c.speed[16]}}, c.speed};
		case (c.op)
			cprp_pkg::OP_READ: begin
				if (pres_unanchored) begin
					pres_start      = now;
					pres_rate       = tick_rate();
					pres_pause      = '0;
					pres_offset     = '0;
					pres_unanchored = 1'b0;
				end
			end
			cprp_pkg::OP_SPEED: begin
				if (spd == '0) begin
					freeze(now);
				end else begin
					mag  = spd[63] ? 64'd0 - spd : spd;
					rate = (tick_rate() * 64'(SPEED_NORMAL_TB)) / mag;
					if (rate == '0)
						rate = 64'd1;
					if (spd[63])
						rate = 64'd0 - rate;
					unfreeze(now);
					pres_start = now - scaled_quot(now - pres_start, rate, pres_rate);
					pres_rate  = rate;
				end
			end
			cprp_pkg::OP_DISC: begin
				pres_start = now;
				if (pres_pause != '0)
					pres_pause = now;
				pres_offset     = {c.pts[62], c.pts};
				pres_unanchored = 1'b0;
			end
			cprp_pkg::OP_PAUSE: freeze(now);
			cprp_pkg::OP_RESUME: unfreeze(now);
			default: ;
		endcase
		held   = (pres_pause != '0) ? pres_pause : now;
		r.play = clamp_add(scaled_quot(held - pres_start, 64'(TIME_BASE_TB), pres_rate),
			pres_offset);
		absq = ({64'd0, now} * 128'(TIME_BASE_TB)) / {64'd0, tick_rate()};
		r.abs_units = (absq[127:63] != '0) ? NOW_MAX : absq[62:0];
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic push_cmd(input logic [2:0] op, input logic [62:0] now, input int spd,
		input logic [62:0] pts);
		clock_cmd_t c;
		c.op    = op;
		c.now   = now;
		c.speed = spd[16:0];
		c.pts   = pts;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_directed();
		push_cmd(OP_SPARE_LO, 63'd1000, 0, '0);        // spare opcode before anchoring
		push_cmd(cprp_pkg::OP_PAUSE, 63'd0, 0, '0);    // pause at count zero does nothing
		push_cmd(cprp_pkg::OP_SPEED, 63'd2000, 2000, '0);  // speed change before anchoring
		push_cmd(cprp_pkg::OP_READ, 63'd5000, 0, PTS_MAX); // first read anchors
		push_cmd(cprp_pkg::OP_READ, 63'd5000000, 0, '0);
		push_cmd(cprp_pkg::OP_READ, 63'd0, 0, '0);
		push_cmd(cprp_pkg::OP_READ, NOW_MAX, 0, '0);
		push_cmd(cprp_pkg::OP_SPEED, 63'd10000000, 2000, '0);
		push_cmd(cprp_pkg::OP_SPEED, 63'd20000000, -1000, '0);
		push_cmd(cprp_pkg::OP_SPEED, 63'd30000000, 64000, '0);
		push_cmd(cprp_pkg::OP_SPEED, 63'd31000000, -64000, '0);
		push_cmd(cprp_pkg::OP_SPEED, 63'd32000000, 1, '0);
		push_cmd(cprp_pkg::OP_SPEED, 63'd33000000, -1, '0);
		push_cmd(cprp_pkg::OP_SPEED, 63'd40000000, 1000, '0);
		push_cmd(cprp_pkg::OP_PAUSE, 63'd50000000, 0, '0);
		push_cmd(cprp_pkg::OP_PAUSE, 63'd60000000, 0, '0);    // already paused: ignore
		push_cmd(cprp_pkg::OP_READ, 63'd70000000, 0, '0);
		push_cmd(cprp_pkg::OP_RESUME, 63'd80000000, 0, '0);
		push_cmd(cprp_pkg::OP_RESUME, 63'd90000000, 0, '0);   // not paused: ignore
		push_cmd(cprp_pkg::OP_SPEED, 63'd100000000, 0, '0);   // zero speed pauses
		push_cmd(cprp_pkg::OP_DISC, 63'd0, 0, PTS_MAX);  // discontinuity at zero drops the pause
		push_cmd(cprp_pkg::OP_READ, NOW_MAX, 0, '0);     // read at the maximum counter value
		push_cmd(cprp_pkg::OP_DISC, 63'd200000000, 0, PTS_MIN);
		push_cmd(cprp_pkg::OP_READ, 63'd0, 0, '0);
		push_cmd(OP_SPARE_HI, NOW_MAX, -64000, PTS_MIN);
	endtask

	// mostly a counter that moves forward, with jumps and corner values mixed in
	task automatic queue_random(input int n);
		clock_cmd_t  c;
		int          r;
		int          spd;
		logic [63:0] w;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				c.op = cprp_pkg::OP_READ;
			else if (r < 55)
				c.op = cprp_pkg::OP_SPEED;
			else if (r < 65)
				c.op = cprp_pkg::OP_DISC;
			else if (r < 78)
				c.op = cprp_pkg::OP_PAUSE;
			else if (r < 92)
				c.op = cprp_pkg::OP_RESUME;
			else
				c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

			r = $urandom_range(0, 99);
			if (r < 85) begin
				w = rand64() >> $urandom_range(24, 63);
				gen_tick = gen_tick + w[62:0];
			end else if (r < 93) begin
				w = rand64();
				gen_tick = w[62:0];
			end else if (r < 96) begin
				gen_tick = '0;
			end else begin
				gen_tick = NOW_MAX;
			end
			c.now = gen_tick;

			r = $urandom_range(0, 99);
			if (r < 30)
				spd = speed_menu[$urandom_range(0, 5)];
			else if (r < 40)
				spd = 0;
			else if (r < 50)
				spd = ($urandom_range(0, 1) != 0) ? 64000 : -64000;
			else if (r < 55)
				spd = ($urandom_range(0, 1) != 0) ? 1 : -1;
			else
				spd = int'($urandom_range(0, 128000)) - 64000;
			c.speed = spd[16:0];

			r = $urandom_range(0, 99);
			if (r < 5) begin
				c.pts = PTS_MAX;
			end else if (r < 10) begin
				c.pts = PTS_MIN;
			end else begin
				w = rand64() >> $urandom_range(1, 63);
				c.pts = w[62:0];
				if ($urandom_range(0, 1) != 0)
					c.pts = 63'd0 - c.pts;
			end
			pending_cmds.push_back(c);
		end
	endtask

	// hold until every queued command is taken and every reading has come back
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || s_tvalid || due_readings.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_freq(input logic [31:0] value);
		@(negedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// command driver: bursts of transfers separated by random gaps when tx_gaps is set
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || cmd_fire) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					next_cmd = pending_cmds.pop_front();
					s_tdata  <= {1'b0, next_cmd.pts, next_cmd.speed, next_cmd.now};
					s_tuser  <= next_cmd.op;
					s_tvalid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left   = tx_gaps ? $urandom_range(1, 300) : 0;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result backpressure: short random stalls or rare long ones, per phase
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			case (rx_mode)
				1: begin
					if ($urandom_range(0, 3) == 0)
						stall_left = $urandom_range(1, 6);
				end
				2: begin
					if ($urandom_range(0, 99) == 0)
						stall_left = $urandom_range(50, 300);
				end
				default: ;
			endcase
		end
	end

	// monitor: check result transfers, then predict for command transfers
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_fire = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got.play      = m_tdata[63:0];
				got.abs_units = m_tdata[126:64];
				if (due_readings.size() == 0) begin
					flag_mismatch($sformatf("result with nothing pending, playing_time %0d",
						$signed(got.play)));
				end else begin
					want = due_readings.pop_front();
					if (got.play !== want.play)
						flag_mismatch($sformatf("reading %0d playing_time got %0d want %0d",
							readings_checked, $signed(got.play), $signed(want.play)));
					if (got.abs_units !== want.abs_units)
						flag_mismatch($sformatf("reading %0d absolute_time got %0d want %0d",
							readings_checked, got.abs_units, want.abs_units));
					readings_checked++;
				end
			end
			if (cfg_we)
				tick_freq = cfg_wdata;
			if (cmd_fire) begin
				seen_cmd.op    = s_tuser;
				seen_cmd.now   = s_tdata[62:0];
				seen_cmd.speed = s_tdata[79:63];
				seen_cmd.pts   = s_tdata[142:80];
				due_readings.push_back(advance_clock(seen_cmd));
				cmds_taken++;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = cprp_pkg::OP_READ;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		freq_plan[4] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_directed();
		wait_idle();

		foreach (freq_plan[i]) begin
			write_freq(freq_plan[i]);
			tx_gaps = (i % 3) != 1;
			rx_mode = i % 3;
			queue_random(RANDOM_PER_SET);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d clock commands and checked %0d readings", cmds_taken,
			readings_checked);
		$display("over %0d counter frequency settings, including 0, 1 and the maximum",
			$size(freq_plan) + 1);
		if (err_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#80_000_000;
		$display("timeout with %0d readings outstanding", due_readings.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
